/* hdl/stick_dead_zone_to_polar_core_defines.svh */
// assertion macros shared by the stick dead zone to polar rtl
`ifndef STICK_DEAD_ZONE_TO_POLAR_CORE_DEFINES_SVH
`define STICK_DEAD_ZONE_TO_POLAR_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SDZP_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SDZP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/sdzp_pkg.sv */
// types, constants and tables for the stick dead zone to polar core
package sdzp_pkg;

    localparam int PLAYER_COUNT_DEF = 8;
    localparam int CORDIC_STEPS     = 30;
    localparam int CELL_COUNT       = 32;
    localparam int DEAD_ZONE        = 12;
    localparam int MASKED_PLAYERS   = 4;
    localparam int XY_W             = 35;
    localparam int Z_W              = 32;
    localparam int SQ_W             = 64;

    localparam logic [15:0] FULL_STRENGTH  = 16'd32768;
    localparam logic [26:0] STRENGTH_COEF  = 27'd92527752;

    localparam logic [1:0] REG_CAMERA_PRESENT = 2'd0;
    localparam logic [1:0] REG_INPUT_ENABLED  = 2'd1;
    localparam logic [1:0] REG_PLAYER_MASK    = 2'd2;

    localparam logic [31:0] ARCTAN [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef struct packed {
        logic        valid;
        logic        active;
        logic        swap;
        logic        a_neg;
        logic        b_neg;
        logic        zero_oct;
        logic        diag;
        logic        cam;
        logic        passed;
        logic [15:0] yaw;
    } sdzp_ctrl_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [SQ_W-1:0]        v;
        logic [SQ_W-1:0]        r;
    } sdzp_work_t;

endpackage

/* hdl/sdzp_front.sv */
// front stages: dead zone, octant fold, pass flag and the cube of the squared radius
module sdzp_front import sdzp_pkg::*; #(
    parameter int PLAYER_COUNT = PLAYER_COUNT_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic signed [7:0] stick_x,
    input  logic signed [7:0] stick_y,
    input  logic [15:0]       camera_yaw,
    input  logic [2:0]        player_index,
    input  logic              camera_present,
    input  logic              input_enabled,
    input  logic [3:0]        player_enable_mask,
    output sdzp_ctrl_t        ctrl_out,
    output sdzp_work_t        work_out
);

    localparam logic signed [7:0] DZ_POS = 8'(DEAD_ZONE);
    localparam logic signed [7:0] DZ_NEG = -8'(DEAD_ZONE);

    logic signed [7:0] a, b;
    logic [6:0]        ua, ub;
    logic              x_out, y_out;
    logic              mask_ok;
    sdzp_ctrl_t        c0_next;

    sdzp_ctrl_t  c0_reg, c1_reg, c2_reg;
    logic [6:0]  xs0_reg, ys0_reg, xs1_reg, ys1_reg;
    logic [14:0] s0_reg, s1_reg;
    logic [29:0] sq1_reg;
    sdzp_work_t  work2_reg;

    always_comb begin
        x_out = (stick_x > DZ_POS) || (stick_x < DZ_NEG);
        y_out = (stick_y > DZ_POS) || (stick_y < DZ_NEG);
        a = (stick_x > DZ_POS) ? stick_x - DZ_POS :
            (stick_x < DZ_NEG) ? stick_x + DZ_POS : 8'sd0;
        b = (stick_y > DZ_POS) ? stick_y - DZ_POS :
            (stick_y < DZ_NEG) ? stick_y + DZ_POS : 8'sd0;
        ua = a[7] ? 7'(-a) : a[6:0];
        ub = b[7] ? 7'(-b) : b[6:0];
        mask_ok = (5'(player_index) >= 5'(MASKED_PLAYERS)) ||
                  player_enable_mask[player_index[1:0]];
        c0_next.valid    = in_valid;
        c0_next.active   = x_out || y_out;
        c0_next.swap     = ub > ua;
        c0_next.a_neg    = a[7];
        c0_next.b_neg    = b[7];
        c0_next.zero_oct = (ub > ua) ? (ua == 7'd0) : (ub == 7'd0);
        c0_next.diag     = ub == ua;
        c0_next.cam      = camera_present;
        c0_next.passed   = (6'(player_index) < 6'(PLAYER_COUNT)) && input_enabled && mask_ok;
        c0_next.yaw      = camera_yaw;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c0_reg <= '0;
            c1_reg <= '0;
            c2_reg <= '0;
        end else if (en) begin
            c0_reg <= c0_next;
            c1_reg <= c0_reg;
            c2_reg <= c1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xs0_reg <= (ub > ua) ? ub : ua;
            ys0_reg <= (ub > ua) ? ua : ub;
            s0_reg  <= 15'(16'(a * a) + 16'(b * b));
            xs1_reg <= xs0_reg;
            ys1_reg <= ys0_reg;
            s1_reg  <= s0_reg;
            sq1_reg <= 30'(s0_reg * s0_reg);
            work2_reg.x <= {4'b0, xs1_reg, 24'b0};
            work2_reg.y <= {4'b0, ys1_reg, 24'b0};
            work2_reg.z <= '0;
            work2_reg.v <= {1'b0, 45'(sq1_reg * s1_reg), 18'b0};
            work2_reg.r <= '0;
        end
    end

    assign ctrl_out = c2_reg;
    assign work_out = work2_reg;

endmodule

/* hdl/sdzp_cell.sv */
// one cell of the chain: a cordic vectoring step below CORDIC_STEPS and one root digit
module sdzp_cell import sdzp_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  sdzp_ctrl_t ctrl_in,
    input  sdzp_work_t work_in,
    output sdzp_ctrl_t ctrl_out,
    output sdzp_work_t work_out
);

    localparam logic [SQ_W-1:0] ROOT_BIT = SQ_W'(1) << (62 - 2 * IDX);

    sdzp_ctrl_t      ctrl_reg;
    sdzp_work_t      work_reg;
    sdzp_work_t      work_next;
    logic [SQ_W-1:0] trial;

    always_comb begin
        work_next = work_in;
        if (IDX < CORDIC_STEPS) begin
            if (!work_in.y[XY_W-1]) begin
                work_next.x = work_in.x + (work_in.y >>> IDX);
                work_next.y = work_in.y - (work_in.x >>> IDX);
                work_next.z = work_in.z + $signed(ARCTAN[IDX % CORDIC_STEPS]);
            end else begin
                work_next.x = work_in.x - (work_in.y >>> IDX);
                work_next.y = work_in.y + (work_in.x >>> IDX);
                work_next.z = work_in.z - $signed(ARCTAN[IDX % CORDIC_STEPS]);
            end
        end
        trial = work_in.r + ROOT_BIT;
        if (work_in.v >= trial) begin
            work_next.v = work_in.v - trial;
            work_next.r = (work_in.r >> 1) + ROOT_BIT;
        end else begin
            work_next.r = work_in.r >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (en) begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            work_reg <= work_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign work_out = work_reg;

endmodule

/* hdl/sdzp_back.sv */
// back stages: octant unfold, camera offset, strength scaling and the output register
module sdzp_back import sdzp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  sdzp_ctrl_t  ctrl_in,
    input  sdzp_work_t  work_in,
    output logic        out_valid,
    output logic [15:0] stick_angle,
    output logic [15:0] stick_strength,
    output logic        passed
);

    localparam logic signed [Z_W-1:0] Z_MAX = 32'sh20000000;

    logic [29:0] t_oct;
    logic [31:0] q, h;
    logic [15:0] m, ang;
    logic [17:0] st;

    logic        v1_reg, act1_reg, pass1_reg;
    logic [15:0] ang1_reg;
    logic [58:0] prod1_reg;
    logic        vo_reg;
    logic [15:0] ang_o_reg, str_o_reg;
    logic        pass_o_reg;

    always_comb begin
        if (ctrl_in.zero_oct) begin
            t_oct = '0;
        end else if (ctrl_in.diag || work_in.z > Z_MAX) begin
            t_oct = Z_MAX[29:0];
        end else if (work_in.z[Z_W-1]) begin
            t_oct = '0;
        end else begin
            t_oct = work_in.z[29:0];
        end
        q   = ctrl_in.swap  ? 32'h40000000 - 32'(t_oct) : 32'(t_oct);
        h   = ctrl_in.a_neg ? 32'h80000000 - q : q;
        m   = ctrl_in.b_neg ? 16'(-h[31:16]) : h[31:16];
        ang = ctrl_in.cam ? m - ctrl_in.yaw : m;
        st  = prod1_reg[58:41];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= ctrl_in.valid;
            vo_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            act1_reg   <= ctrl_in.active;
            pass1_reg  <= ctrl_in.passed;
            ang1_reg   <= ang;
            prod1_reg  <= 59'(work_in.r[31:0] * STRENGTH_COEF);
            ang_o_reg  <= act1_reg ? ang1_reg : 16'd0;
            str_o_reg  <= !act1_reg ? 16'd0 :
                          (st > 18'(FULL_STRENGTH)) ? FULL_STRENGTH : st[15:0];
            pass_o_reg <= pass1_reg;
        end
    end

    assign out_valid      = vo_reg;
    assign stick_angle    = ang_o_reg;
    assign stick_strength = str_o_reg;
    assign passed         = pass_o_reg;

endmodule

/* hdl/stick_dead_zone_to_polar_core.sv */
// Stick dead zone to polar core: one signed stick sample per beat becomes a binary-angle
// direction and a Q1.15 strength. A new beat is taken every clock cycle while the output
// is free or being taken; each accepted beat goes through three front stages (dead zone
// and fold, square, cube), a chain of 32 cells that each run one square root digit and,
// for cells below CORDIC_STEPS, one cordic vectoring step, and two back stages (unfold
// and the strength multiply, then the output register). A stalled output holds the
// whole chain. Configuration writes are taken every cycle and belong to quiet periods.
`include "stick_dead_zone_to_polar_core_defines.svh"

module stick_dead_zone_to_polar_core import sdzp_pkg::*; #(
    parameter int PLAYER_COUNT = PLAYER_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // stick_x [7:0], stick_y [15:8], camera_yaw [31:16]
    input  logic [2:0]  s_tuser,   // player_index [2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // stick_angle [15:0], stick_strength [31:16]
    output logic        m_tuser,   // passed [0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic        camera_present_reg, input_enabled_reg;
    logic [3:0]  player_mask_reg;
    logic        en;
    logic [15:0] angle, strength;

    sdzp_ctrl_t ctrl_chain [CELL_COUNT+1];
    sdzp_work_t work_chain [CELL_COUNT+1];

    assign cfg_ready = 1'b1;
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            camera_present_reg <= 1'b0;
            input_enabled_reg  <= 1'b0;
            player_mask_reg    <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CAMERA_PRESENT: camera_present_reg <= cfg_data[0];
                REG_INPUT_ENABLED:  input_enabled_reg  <= cfg_data[0];
                REG_PLAYER_MASK:    player_mask_reg    <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    sdzp_front #(.PLAYER_COUNT(PLAYER_COUNT)) u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .en                 (en),
        .in_valid           (s_tvalid),
        .stick_x            ($signed(s_tdata[7:0])),
        .stick_y            ($signed(s_tdata[15:8])),
        .camera_yaw         (s_tdata[31:16]),
        .player_index       (s_tuser),
        .camera_present     (camera_present_reg),
        .input_enabled      (input_enabled_reg),
        .player_enable_mask (player_mask_reg),
        .ctrl_out           (ctrl_chain[0]),
        .work_out           (work_chain[0])
    );

    for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
        sdzp_cell #(.IDX(k)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .ctrl_in  (ctrl_chain[k]),
            .work_in  (work_chain[k]),
            .ctrl_out (ctrl_chain[k+1]),
            .work_out (work_chain[k+1])
        );
    end

    sdzp_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (en),
        .ctrl_in        (ctrl_chain[CELL_COUNT]),
        .work_in        (work_chain[CELL_COUNT]),
        .out_valid      (m_tvalid),
        .stick_angle    (angle),
        .stick_strength (strength),
        .passed         (m_tuser)
    );

    assign m_tdata = {strength, angle};

    `SDZP_ASSERT(a_strength_range, m_tvalid, strength <= FULL_STRENGTH, "strength above full")
    `SDZP_ASSERT(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready, "input taken in stall")
    `SDZP_ASSERT_NEXT(a_mask_write, cfg_valid && cfg_index == REG_PLAYER_MASK,
        player_mask_reg == $past(cfg_data[3:0]), "mask write lost")

endmodule
